FILE: hdl/ise_pkg.sv
// ise_pkg: shared constants, register codes and types for the inverted sobel edge filter
// no dependencies; compiled first

package ise_pkg;

	// frame geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_DIM    = 3;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// configuration register widths and reset values
	localparam int WREG_W = 11;
	localparam int HREG_W = 13;
	localparam logic [WREG_W-1:0] WIDTH_RST  = WREG_W'(640);
	localparam logic [HREG_W-1:0] HEIGHT_RST = HREG_W'(480);

	// apb port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int IDX_W  = ADDR_W - 2;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

	// pixel and window
	localparam int CHAN_W = 8;
	localparam int LANES  = 3;
	localparam int PIX_W  = CHAN_W * LANES;
	localparam int WIN_N  = 9;
	localparam int HIST_N = WIN_N - 3;

	// lane arithmetic
	localparam int GRAD_W     = 11;
	localparam int SQ_W       = 21;
	localparam int SUM_W      = 22;
	localparam int RAD_W      = 2 * CHAN_W;
	localparam int ROOT_STEPS = CHAN_W;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int REM_W      = CHAN_W + 1;
	localparam int TRIAL_W    = CHAN_W + 3;
	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	typedef logic [WIN_N-1:0][PIX_W-1:0]  pix_win_t;
	typedef logic [WIN_N-1:0][CHAN_W-1:0] chan_win_t;

	// position and tags of the centre pixel
	typedef struct packed {
		logic             hit;
		logic             last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} pos_t;

	// window sequencing strobes
	typedef struct packed {
		logic accept;
		logic fetch;
	} win_ctl_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic              done;
		logic [CHAN_W-1:0] value;
	} lane_out_t;

endpackage

FILE: hdl/ise_pix_if.sv
// ise_pix_if: valid/ready channel carrying one rgb pixel word
// depends on ise_pkg

interface ise_pix_if;
	import ise_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] in_red;
	logic [CHAN_W-1:0] in_green;
	logic [CHAN_W-1:0] in_blue;
	logic              frame_start;

	modport source (output valid, in_red, in_green, in_blue, frame_start, input ready);
	modport sink (input valid, in_red, in_green, in_blue, frame_start, output ready);
endinterface

FILE: hdl/ise_res_if.sv
// ise_res_if: valid/ready channel carrying one filtered result word
// depends on ise_pkg

interface ise_res_if;
	import ise_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic [COL_W-1:0]  out_col;
	logic [ROW_W-1:0]  out_row;
	logic              frame_last;

	modport source (output valid, out_red, out_green, out_blue, out_col, out_row, frame_last,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_col, out_row, frame_last,
		output ready);
endinterface

FILE: hdl/ise_window.sv
// ise_window: raster position counters, two line stores and the 3x3 pixel window
// depends on ise_pkg

module ise_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ise_pkg::win_ctl_t          ctl,
	input  logic [ise_pkg::WREG_W-1:0] frame_width,
	input  logic [ise_pkg::HREG_W-1:0] frame_height,
	input  logic [ise_pkg::PIX_W-1:0]  pix,
	input  logic                       frame_start,
	output ise_pkg::pix_win_t          win,
	output ise_pkg::pos_t              pos
);
	import ise_pkg::*;

	logic [WREG_W-1:0] w_lim;
	logic [HREG_W-1:0] h_lim;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_cur;
	logic [ROW_W-1:0]  row_cur;
	logic [COL_W-1:0]  col_clip;
	logic [WREG_W-1:0] col_next;
	logic [HREG_W-1:0] row_next;
	pos_t              pos_d;

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [COL_W-1:0] addr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] up_s1;
	logic [PIX_W-1:0] mid_s1;
	pos_t             pos_s1;

	logic [PIX_W-1:0] hist_q [HIST_N];

	// clamp the frame size to the supported range
	always_comb begin
		w_lim = frame_width;
		if (frame_width < WREG_W'(MIN_DIM)) begin
			w_lim = WREG_W'(MIN_DIM);
		end else if (frame_width > WREG_W'(MAX_WIDTH)) begin
			w_lim = WREG_W'(MAX_WIDTH);
		end
		h_lim = frame_height;
		if (frame_height < HREG_W'(MIN_DIM)) begin
			h_lim = HREG_W'(MIN_DIM);
		end else if (frame_height > HREG_W'(MAX_HEIGHT)) begin
			h_lim = HREG_W'(MAX_HEIGHT);
		end
	end

	// position of the incoming pixel, column pulled back after a width change
	always_comb begin
		col_cur  = frame_start ? '0 : col_q;
		row_cur  = frame_start ? '0 : row_q;
		col_clip = col_cur;
		if (WREG_W'(col_cur) >= w_lim) begin
			col_clip = COL_W'(w_lim - WREG_W'(1));
		end
		col_next  = WREG_W'(col_cur) + WREG_W'(1);
		row_next  = HREG_W'(row_cur) + HREG_W'(1);
		pos_d.hit  = (col_clip >= COL_W'(2)) && (row_cur >= ROW_W'(2));
		pos_d.last = (WREG_W'(col_clip) == w_lim - WREG_W'(1)) &&
			(HREG_W'(row_cur) == h_lim - HREG_W'(1));
		pos_d.col  = col_clip - COL_W'(1);
		pos_d.row  = row_cur - ROW_W'(1);
	end

	// raster counters, wrap at end of line and frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.accept) begin
			if (col_next >= w_lim) begin
				col_q <= '0;
				row_q <= (row_next >= h_lim) ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
				row_q <= row_cur;
			end
		end
	end

	// line stores: read on accept, written back on the fetch that follows
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			up_s1   <= upper_mem[col_clip];
			mid_s1  <= middle_mem[col_clip];
			addr_s1 <= col_clip;
			pix_s1  <= pix;
			pos_s1  <= pos_d;
		end
		if (ctl.fetch) begin
			upper_mem[addr_s1]  <= mid_s1;
			middle_mem[addr_s1] <= pix_s1;
		end
	end

	// two older window columns shift by one column per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
		end else if (ctl.fetch) begin
			for (int i = 0; i < HIST_N - 3; i++) begin
				hist_q[i] <= hist_q[i+3];
			end
			hist_q[HIST_N-3] <= up_s1;
			hist_q[HIST_N-2] <= mid_s1;
			hist_q[HIST_N-1] <= pix_s1;
		end
	end

	// window: column-major, top row first
	always_comb begin
		for (int i = 0; i < HIST_N; i++) begin
			win[i] = hist_q[i];
		end
		win[HIST_N]   = up_s1;
		win[HIST_N+1] = mid_s1;
		win[HIST_N+2] = pix_s1;
	end

	assign pos = pos_s1;

endmodule

FILE: hdl/ise_lane.sv
// ise_lane: one color channel: sobel sums, squares and an iterative square root
// depends on ise_pkg

module ise_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ise_pkg::chan_win_t win,
	output ise_pkg::lane_out_t res
);
	import ise_pkg::*;

	typedef enum logic [2:0] {L_IDLE, L_GRAD, L_SQR, L_SUM, L_ROOT} lane_state_t;

	lane_state_t               state_q;
	chan_win_t                 a_q;
	logic signed [GRAD_W-1:0]  gx_q;
	logic signed [GRAD_W-1:0]  gy_q;
	logic [SQ_W-1:0]           sqx_q;
	logic [SQ_W-1:0]           sqy_q;
	logic [RAD_W-1:0]          rad_q;
	logic                      sat_q;
	logic [REM_W-1:0]          rem_q;
	logic [CHAN_W-1:0]         root_q;
	logic [STEP_W-1:0]         step_q;
	logic                      done_q;
	logic [CHAN_W-1:0]         value_q;

	logic signed [GRAD_W-1:0]   e [WIN_N];
	logic signed [GRAD_W-1:0]   gx_d;
	logic signed [GRAD_W-1:0]   gy_d;
	logic signed [2*GRAD_W-1:0] prod_x;
	logic signed [2*GRAD_W-1:0] prod_y;
	logic [SUM_W-1:0]           sum_d;
	logic [TRIAL_W-1:0]         rem_sh;
	logic [TRIAL_W-1:0]         trial;
	logic [TRIAL_W-1:0]         rem_n;
	logic [CHAN_W-1:0]          root_n;

	// horizontal and vertical 1-2-1 sums
	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			e[i] = $signed({{(GRAD_W-CHAN_W){1'b0}}, a_q[i]});
		end
		gy_d = e[0] + (e[3] <<< 1) + e[6] - e[2] - (e[5] <<< 1) - e[8];
		gx_d = e[0] + (e[1] <<< 1) + e[2] - e[6] - (e[7] <<< 1) - e[8];
	end

	// squares, one multiplier per axis
	assign prod_x = gx_q * gx_q;
	assign prod_y = gy_q * gy_q;
	assign sum_d  = SUM_W'(sqx_q) + SUM_W'(sqy_q);

	// one root bit per step: restoring shift-subtract
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		if (rem_sh >= trial) begin
			rem_n  = rem_sh - trial;
			root_n = {root_q[CHAN_W-2:0], 1'b1};
		end else begin
			rem_n  = rem_sh;
			root_n = {root_q[CHAN_W-2:0], 1'b0};
		end
	end

	// lane sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			a_q     <= '0;
			gx_q    <= '0;
			gy_q    <= '0;
			sqx_q   <= '0;
			sqy_q   <= '0;
			rad_q   <= '0;
			sat_q   <= 1'b0;
			rem_q   <= '0;
			root_q  <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						a_q     <= win;
						state_q <= L_GRAD;
					end
				end
				L_GRAD: begin
					gx_q    <= gx_d;
					gy_q    <= gy_d;
					state_q <= L_SQR;
				end
				L_SQR: begin
					sqx_q   <= prod_x[SQ_W-1:0];
					sqy_q   <= prod_y[SQ_W-1:0];
					state_q <= L_SUM;
				end
				L_SUM: begin
					rad_q   <= sum_d[RAD_W-1:0];
					sat_q   <= |sum_d[SUM_W-1:RAD_W];
					rem_q   <= '0;
					root_q  <= '0;
					step_q  <= STEP_W'(ROOT_STEPS - 1);
					state_q <= L_ROOT;
				end
				L_ROOT: begin
					rem_q  <= rem_n[REM_W-1:0];
					root_q <= root_n;
					rad_q  <= rad_q << 2;
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						// saturated magnitude inverts to zero
						value_q <= sat_q ? '0 : CHAN_MAX - root_n;
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.value = value_q;

endmodule

FILE: hdl/ise_merge.sv
// ise_merge: joins the three lane values with the position tags into the output register
// depends on ise_pkg and ise_res_if

module ise_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ise_pkg::lane_out_t lanes [ise_pkg::LANES],
	input  ise_pkg::pos_t      pos,
	output logic               room,
	ise_res_if.source          result
);
	import ise_pkg::*;

	logic              valid_q;
	logic [CHAN_W-1:0] red_q;
	logic [CHAN_W-1:0] green_q;
	logic [CHAN_W-1:0] blue_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_q;

	// output word may be replaced once taken
	assign room = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload of the output word
	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= lanes[0].value;
			green_q <= lanes[1].value;
			blue_q  <= lanes[2].value;
			col_q   <= pos.col;
			row_q   <= pos.row;
			last_q  <= pos.last;
		end
	end

	assign result.valid      = valid_q;
	assign result.out_red    = red_q;
	assign result.out_green  = green_q;
	assign result.out_blue   = blue_q;
	assign result.out_col    = col_q;
	assign result.out_row    = row_q;
	assign result.frame_last = last_q;

	// interior centres never sit on row or column zero
	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (col_q != '0 && row_q != '0))
		else $error("output word tagged with a border position");

endmodule

FILE: hdl/inverted_sobel_edge_filter_core.sv
// Inverted sobel edge filter core: line stores and window, three channel lanes, output merge.
// An interior word passes the line store fetch, the lane steps (gradient, square, sum and an
// eight-step square root) and the output register; border positions produce no word.
// One pixel word at a time: the next waits for fetch and, if interior, for the result load.
// Reset (arst_n low, asynchronous): position 0,0, window cleared, 640x480, output empty;
// the line stores are not cleared and are refilled by the first two lines.

module inverted_sobel_edge_filter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ise_pkg::ADDR_W-1:0] paddr,
	input  logic [ise_pkg::DATA_W-1:0] pwdata,
	output logic [ise_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	ise_pix_if.sink                    pixel,
	ise_res_if.source                  result
);
	import ise_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_CALC, S_EMIT} state_t;

	state_t            state_q;
	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [IDX_W-1:0]  reg_idx;
	logic              cfg_wr;

	win_ctl_t   ctl;
	pix_win_t   win;
	pos_t       pos;
	chan_win_t  lane_win [LANES];
	lane_out_t  lane_out [LANES];
	logic       lane_start;
	logic       room;
	logic       load;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  width_q  <= pwdata[WREG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[HREG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(height_q);
		endcase
	end

	// item sequencing
	assign pixel.ready = (state_q == S_IDLE);
	assign ctl.accept  = pixel.valid && pixel.ready;
	assign ctl.fetch   = (state_q == S_FETCH);
	assign lane_start  = ctl.fetch && pos.hit;
	assign load        = room && ((state_q == S_CALC && lane_out[0].done) ||
		state_q == S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.accept) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= pos.hit ? S_CALC : S_IDLE;
				end
				S_CALC: begin
					if (lane_out[0].done) begin
						state_q <= room ? S_IDLE : S_EMIT;
					end
				end
				S_EMIT: begin
					if (room) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// window and line stores
	ise_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.frame_width  (width_q),
		.frame_height (height_q),
		.pix          ({pixel.in_red, pixel.in_green, pixel.in_blue}),
		.frame_start  (pixel.frame_start),
		.win          (win),
		.pos          (pos)
	);

	// split the window by channel: lane 0 red, 1 green, 2 blue
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			for (int i = 0; i < WIN_N; i++) begin
				lane_win[k][i] = win[i][CHAN_W*(LANES-1-k) +: CHAN_W];
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		ise_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.win    (lane_win[k]),
			.res    (lane_out[k])
		);
	end

	// output word
	ise_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.lanes  (lane_out),
		.pos    (pos),
		.room   (room),
		.result (result)
	);

	// lanes run in lockstep
	a_lane_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_out[0].done == lane_out[1].done) && (lane_out[1].done == lane_out[2].done))
		else $error("channel lanes out of step");

	// a lane only finishes while the sequencer waits for it
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		lane_out[0].done |-> state_q == S_CALC)
		else $error("lane result outside calc state");

	// an accepted word always goes to the line store fetch next
	a_accept_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> state_q == S_FETCH)
		else $error("accepted word skipped fetch");

endmodule

FILE: dv/inverted_sobel_edge_filter_core_checker.sv
`timescale 1ns / 100ps
// inverted_sobel_edge_filter_core_checker: snoops the register port and both word channels,
// predicts every filtered word and compares it with what the core returns
// depends on ise_pkg, ise_pix_if and ise_res_if

module inverted_sobel_edge_filter_core_checker
	import ise_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	ise_pix_if                pixel,
	ise_res_if                result,
	output int                fail_count,
	output int                pending,
	output int                pixel_count,
	output int                word_count,
	output int                frame_count
);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              last;
	} edge_word_t;

	// predicted words, oldest first
	edge_word_t        expected_words[$];

	// shadow of the core: line stores, two older window columns, position, sizes
	bit [PIX_W-1:0]    upper_line[MAX_WIDTH];
	bit [PIX_W-1:0]    middle_line[MAX_WIDTH];
	bit [PIX_W-1:0]    prior_cols[HIST_N];
	int                next_col;
	int                next_row;
	logic [WREG_W-1:0] width_reg;
	logic [HREG_W-1:0] height_reg;

	function automatic int clamp_dim(int v, int hi);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// sobel pair on one channel, floor root capped at 255, then inverted
	// window is indexed row * 3 + col
	function automatic logic [CHAN_W-1:0] channel_edge(pix_win_t nbhd, int shift);
		int v[3][3];
		int gx, gy, sum_sq, root;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				v[r][c] = int'(nbhd[r * 3 + c][shift +: CHAN_W]);
		gx = (v[0][0] + 2 * v[1][0] + v[2][0]) - (v[0][2] + 2 * v[1][2] + v[2][2]);
		gy = (v[0][0] + 2 * v[0][1] + v[0][2]) - (v[2][0] + 2 * v[2][1] + v[2][2]);
		sum_sq = gx * gx + gy * gy;
		root = 0;
		while (root < 255 && (root + 1) * (root + 1) <= sum_sq)
			root++;
		return CHAN_MAX - CHAN_W'(root);
	endfunction

	function automatic string word_text(edge_word_t wd);
		return $sformatf("rgb %0d/%0d/%0d col %0d row %0d last %0b",
			wd.red, wd.green, wd.blue, wd.col, wd.row, wd.last);
	endfunction

	task automatic count_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int               w, h, c, r;
		bit [PIX_W-1:0]   pix, up, mid;
		pix_win_t         nbhd;
		edge_word_t       want, got;
		if (!arst_n) begin
			for (int k = 0; k < HIST_N; k++)
				prior_cols[k] = '0;
			next_col = 0;
			next_row = 0;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			expected_words.delete();
			fail_count = 0;
			pixel_count = 0;
			word_count = 0;
			frame_count = 0;
		end else begin
			// register write completes in the access cycle
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_FRAME_WIDTH:  width_reg = pwdata[WREG_W-1:0];
					REG_FRAME_HEIGHT: height_reg = pwdata[HREG_W-1:0];
					default: ;
				endcase
			end

			// pixel word: update shadow state and predict at most one result
			if (pixel.valid && pixel.ready) begin
				pixel_count++;
				pix = {pixel.in_red, pixel.in_green, pixel.in_blue};
				w = clamp_dim(int'(width_reg), MAX_WIDTH);
				h = clamp_dim(int'(height_reg), MAX_HEIGHT);
				if (pixel.frame_start) begin
					next_col = 0;
					next_row = 0;
				end
				// a column left stale by a narrower width sits on the last column
				c = (next_col >= w) ? w - 1 : next_col;
				r = next_row;
				up = upper_line[c];
				mid = middle_line[c];
				upper_line[c] = mid;
				middle_line[c] = pix;

				if (c >= 2 && r >= 2) begin
					for (int k = 0; k < 3; k++) begin
						nbhd[k * 3] = prior_cols[k];
						nbhd[k * 3 + 1] = prior_cols[3 + k];
					end
					nbhd[2] = up;
					nbhd[5] = mid;
					nbhd[8] = pix;
					want.red = channel_edge(nbhd, 2 * CHAN_W);
					want.green = channel_edge(nbhd, CHAN_W);
					want.blue = channel_edge(nbhd, 0);
					want.col = COL_W'(c - 1);
					want.row = ROW_W'(r - 1);
					want.last = (c == w - 1) && (r == h - 1);
					expected_words.push_back(want);
				end

				for (int k = 0; k < 3; k++)
					prior_cols[k] = prior_cols[3 + k];
				prior_cols[3] = up;
				prior_cols[4] = mid;
				prior_cols[5] = pix;

				// advance on the unclamped counters, wrap line then frame
				if (next_col + 1 >= w) begin
					next_col = 0;
					next_row = (next_row + 1 >= h) ? 0 : (next_row + 1) % MAX_HEIGHT;
				end else
					next_col = (next_col + 1) % MAX_WIDTH;
			end

			// result word against the oldest prediction
			if (result.valid && result.ready) begin
				word_count++;
				got.red = result.out_red;
				got.green = result.out_green;
				got.blue = result.out_blue;
				got.col = result.out_col;
				got.row = result.out_row;
				got.last = result.frame_last;
				if (got.last)
					frame_count++;
				if (expected_words.size() == 0)
					count_failure({"result word with none expected: ", word_text(got)});
				else begin
					want = expected_words.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.col !== want.col ||
						got.row !== want.row || got.last !== want.last)
						count_failure({"result word mismatch, expected ", word_text(want),
							", got ", word_text(got)});
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

FILE: dv/inverted_sobel_edge_filter_core_tb.sv
`timescale 1ns / 100ps
// inverted_sobel_edge_filter_core_tb: clock, reset, register writes and pixel/result traffic
// for the core; the checker instantiated beside it predicts and compares every word
// depends on ise_pkg, ise_pix_if, ise_res_if, the core and the checker

module inverted_sobel_edge_filter_core_tb;
	import ise_pkg::*;

	localparam int RANDOM_PIXELS = 500;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 20000;

	// pixel content styles
	typedef enum int {TEX_NOISE, TEX_BINARY, TEX_FLAT, TEX_RAMP} texture_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count, pending, pixel_count, word_count, frame_count;

	bit src_gaps;
	bit sink_gaps;
	bit hold_request;
	int eff_width;
	int eff_height;

	ise_pix_if pix_ch ();
	ise_res_if res_ch ();

	inverted_sobel_edge_filter_core dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.pixel(pix_ch), .result(res_ch)
	);

	inverted_sobel_edge_filter_core_checker edge_check (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.pixel(pix_ch), .result(res_ch),
		.fail_count, .pending, .pixel_count, .word_count, .frame_count
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(20_000_000);
		$display("inverted_sobel_edge_filter_core_tb NOT OK");
		$finish;
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else
				res_ch.ready = 1'b1;
		end
	end

	function automatic logic [CHAN_W-1:0] texel(texture_t kind, int idx);
		case (kind)
			TEX_BINARY: return $urandom_range(0, 1) ? CHAN_MAX : 8'h00;
			TEX_FLAT:   return CHAN_W'(120 + $urandom_range(0, 12));
			TEX_RAMP:   return CHAN_W'(idx * 9 + $urandom_range(0, 3));
			default:    return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one pixel word, with an optional gap in front of it
	task automatic send_pixel(input logic [CHAN_W-1:0] red, green, blue, input logic start);
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			pix_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.in_red = red;
		pix_ch.in_green = green;
		pix_ch.in_blue = blue;
		pix_ch.frame_start = start;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
	endtask

	// raster run of one texture, with rare frame restarts mid-frame
	task automatic send_run(input int count, input bit start_first, input int restart_permille);
		texture_t kind;
		kind = texture_t'($urandom_range(0, 3));
		for (int i = 0; i < count; i++)
			send_pixel(texel(kind, i), texel(kind, i + 40), texel(kind, 3 * i),
				(i == 0 && start_first) || $urandom_range(0, 999) < restart_permille);
	endtask

	// stop offering pixels and let every predicted word come back
	task automatic wait_drained();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// new frame size on an idle core; a wider frame must open with a frame start
	// so no line store column is read before it was filled
	task automatic set_size(input int width_val, input int height_val, output bit need_start);
		int new_w;
		wait_drained();
		write_reg(REG_FRAME_WIDTH, width_val);
		write_reg(REG_FRAME_HEIGHT, height_val);
		new_w = width_val < MIN_DIM ? MIN_DIM : (width_val > MAX_WIDTH ? MAX_WIDTH : width_val);
		need_start = new_w > eff_width;
		eff_width = new_w;
		eff_height = height_val < MIN_DIM ? MIN_DIM :
			(height_val > MAX_HEIGHT ? MAX_HEIGHT : height_val);
	endtask

	initial begin
		bit fresh;
		int w_val, h_val, count, phase, rand_sent;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.in_red = '0;
		pix_ch.in_green = '0;
		pix_ch.in_blue = '0;
		pix_ch.frame_start = 1'b0;
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		hold_request = 1'b0;
		eff_width = 640;
		eff_height = 480;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size: two full lines of 640, then a few interior words
		send_run(2 * 640 + 8, 1'b1, 0);

		// smallest frame: saturated vertical edge in red, flat green, mild edge in blue
		set_size(3, 3, fresh);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 3 == 0) ? CHAN_MAX : 8'h00, 8'h00, (i < 3) ? 8'd10 : 8'd00, i == 0);
		// next frame by wrap alone, cut short by a frame start
		for (int i = 0; i < 4; i++)
			send_pixel(texel(TEX_NOISE, i), texel(TEX_NOISE, i), texel(TEX_NOISE, i), 1'b0);
		// dark corner in an all-ones red, all-ones green, noisy blue
		for (int i = 0; i < 9; i++)
			send_pixel((i == 0) ? 8'h00 : CHAN_MAX, CHAN_MAX, texel(TEX_NOISE, i), i == 0);

		// random sizes, mostly small, some out of range; stale positions carried over
		phase = 0;
		rand_sent = 0;
		while (rand_sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0: w_val = $urandom_range(0, 2);
				1: w_val = $urandom_range(1025, 2047);
				default: w_val = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: h_val = $urandom_range(0, 2);
				1: h_val = $urandom_range(4097, 8191);
				default: h_val = $urandom_range(3, 7);
			endcase
			// the long result stall needs a small frame so interior words pile up
			if (phase == 2) begin
				w_val = $urandom_range(3, 8);
				h_val = $urandom_range(3, 7);
			end
			set_size(w_val, h_val, fresh);
			src_gaps = $urandom_range(0, 2) != 0;
			sink_gaps = $urandom_range(0, 2) != 0;
			if (eff_width > 16)
				count = $urandom_range(1, 40);
			else if (eff_height > 16)
				count = eff_width * $urandom_range(2, 10);
			else
				count = eff_width * eff_height * $urandom_range(0, 3) +
					$urandom_range(1, eff_width * eff_height);
			// core backs up behind a long result stall while pixels keep coming
			if (phase == 2) begin
				hold_request = 1'b1;
				if (count < 60)
					count = 60;
			end
			send_run(count, fresh || $urandom_range(0, 1) == 0, 15);
			rand_sent += count;
			phase++;
		end

		// closing part with no gaps: narrow frame, height register above range
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		set_size(3, 8191, fresh);
		send_run(3 * 50, 1'b1, 0);

		@(negedge clk);
		pix_ch.valid = 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d pixel words and %0d result words over %0d completed frames",
			pixel_count, word_count, frame_count);
		$display("sizes from 3x3 to 640x480, clamped registers, stale and restarted positions");
		if (pending != 0)
			$display("%0d predicted result words never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("inverted_sobel_edge_filter_core_tb OK");
		else
			$display("inverted_sobel_edge_filter_core_tb NOT OK");
		$finish;
	end

endmodule

FILE: inverted_sobel_edge_filter_core.f
hdl/ise_pkg.sv
hdl/ise_pix_if.sv
hdl/ise_res_if.sv
hdl/ise_window.sv
hdl/ise_lane.sv
hdl/ise_merge.sv
hdl/inverted_sobel_edge_filter_core.sv
dv/inverted_sobel_edge_filter_core_checker.sv
dv/inverted_sobel_edge_filter_core_tb.sv
